>>> hdl/chm_pkg.sv
// shared constants, types and control records for the chained hash map engine
// no dependencies; imported by the interfaces and every module
package chm_pkg;

    localparam int BUCKETS    = 128;
    localparam int POOL_SIZE  = 256;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 9;
    localparam int MODE_BITS  = 2;
    localparam int STAT_BITS  = 2;

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int IDX_W  = $clog2(POOL_SIZE);
    localparam int LINK_W = $clog2(POOL_SIZE + 1);

    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_val;
    typedef logic [BKT_W-1:0]      t_bkt;
    typedef logic [IDX_W-1:0]      t_idx;
    typedef logic [LINK_W-1:0]     t_link;
    typedef logic [MODE_BITS-1:0]  t_mode;
    typedef logic [STAT_BITS-1:0]  t_stat;

    localparam t_link NIL_LINK  = t_link'(POOL_SIZE);
    localparam t_link POOL_LAST = t_link'(POOL_SIZE);

    localparam t_mode MODE_LOOKUP = 2'd0;
    localparam t_mode MODE_INSERT = 2'd1;
    localparam t_mode MODE_REMOVE = 2'd2;
    localparam t_mode MODE_CREATE = 2'd3;

    localparam t_stat ST_HIT    = 2'd0;
    localparam t_stat ST_NEW    = 2'd1;
    localparam t_stat ST_ABSENT = 2'd2;
    localparam t_stat ST_FULL   = 2'd3;

    typedef struct packed {
        logic  in_ready;
        logic  head_rd;
        logic  head_load;
        logic  ent_rd;
        logic  ent_rd_free;
        logic  advance;
        logic  wr_val_upd;
        logic  unlink;
        logic  free_push;
        logic  pop_free;
        logic  bump;
        logic  create;
        logic  res_ld;
        t_stat res_status;
        logic  out_ld;
    } t_cmd;

    typedef struct packed {
        logic  req_valid;
        logic  out_free;
        logic  cur_nil;
        logic  step_limit;
        logic  key_match;
        logic  free_nil;
        logic  pool_full;
        t_mode mode;
    } t_sts;

    function automatic t_bkt bucket_of(input t_key key);
        return t_bkt'(key >> 2);
    endfunction

endpackage

>>> hdl/chm_if.sv
// request, response and configuration channels of the chained hash map engine
// depends on chm_pkg
interface chm_req_if;
    import chm_pkg::*;
    logic  valid;
    logic  ready;
    t_mode mode;
    t_key  key;
    t_val  value;
    modport source (output valid, mode, key, value, input ready);
    modport sink   (input valid, mode, key, value, output ready);
endinterface

interface chm_rsp_if;
    import chm_pkg::*;
    logic                  valid;
    logic                  ready;
    t_val                  result_value;
    t_stat                 status;
    logic [COUNT_BITS-1:0] entry_count;
    modport source (output valid, result_value, status, entry_count, input ready);
    modport sink   (input valid, result_value, status, entry_count, output ready);
endinterface

interface chm_cfg_if;
    import chm_pkg::*;
    logic valid;
    logic ready;
    t_val data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> hdl/chm_ctrl.sv
// request sequencer: bucket read, chain walk, update, unlink, allocation
// depends on chm_pkg; drives chm_dp through t_cmd and reads t_sts
module chm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  chm_pkg::t_sts i_sts,
    output chm_pkg::t_cmd o_cmd
);
    import chm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_HRD, S_HEAD, S_ERD, S_ECMP, S_HIT,
        S_FREE, S_MISS, S_POP, S_NEW, S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    assign o_cmd = cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (i_sts.req_valid) begin
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                cmd.head_rd = 1'b1;
                n_state     = S_HEAD;
            end
            S_HEAD: begin
                cmd.head_load = 1'b1;
                n_state       = S_ERD;
            end
            S_ERD: begin
                if (i_sts.cur_nil || i_sts.step_limit) begin
                    n_state = S_MISS;
                end else begin
                    cmd.ent_rd = 1'b1;
                    n_state    = S_ECMP;
                end
            end
            S_ECMP: begin
                if (i_sts.key_match) begin
                    n_state = S_HIT;
                end else begin
                    cmd.advance = 1'b1;
                    n_state     = S_ERD;
                end
            end
            S_HIT: begin
                cmd.res_ld     = 1'b1;
                cmd.res_status = ST_HIT;
                cmd.wr_val_upd = (i_sts.mode == MODE_INSERT);
                if (i_sts.mode == MODE_REMOVE) begin
                    cmd.unlink = 1'b1;
                    n_state    = S_FREE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FREE: begin
                cmd.free_push = 1'b1;
                n_state       = S_DONE;
            end
            S_MISS: begin
                if (i_sts.mode == MODE_LOOKUP || i_sts.mode == MODE_REMOVE) begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_ABSENT;
                    n_state        = S_DONE;
                end else if (!i_sts.free_nil) begin
                    cmd.ent_rd_free = 1'b1;
                    n_state         = S_POP;
                end else if (!i_sts.pool_full) begin
                    cmd.bump = 1'b1;
                    n_state  = S_NEW;
                end else begin
                    cmd.res_ld     = 1'b1;
                    cmd.res_status = ST_FULL;
                    n_state        = S_DONE;
                end
            end
            S_POP: begin
                cmd.pop_free = 1'b1;
                n_state      = S_NEW;
            end
            S_NEW: begin
                cmd.create     = 1'b1;
                cmd.res_ld     = 1'b1;
                cmd.res_status = ST_NEW;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    cmd.out_ld = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hdl/chm_dp.sv
// datapath: request registers, bucket head and entry memories, free list,
// counters and the response register; depends on chm_pkg and chm_if
module chm_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    chm_req_if.sink       i_req,
    chm_rsp_if.source     o_rsp,
    chm_cfg_if.sink       i_cfg,
    input  chm_pkg::t_cmd i_cmd,
    output chm_pkg::t_sts o_sts
);
    import chm_pkg::*;

    // request and walk registers
    t_mode r_mode;
    t_key  r_key;
    t_val  r_val;
    t_bkt  r_bkt;
    t_val  r_default;
    t_link r_cur;
    t_link r_prev;
    t_link r_head;
    t_link r_slot;
    t_link r_steps;
    t_link r_free_head;
    t_link r_fill;
    t_link r_live;

    // memories and their read registers
    t_key  m_key  [POOL_SIZE];
    t_val  m_val  [POOL_SIZE];
    t_link m_next [POOL_SIZE];
    t_link m_head [BUCKETS];
    logic [BUCKETS-1:0] r_hvalid;
    t_key  r_rd_key;
    t_val  r_rd_val;
    t_link r_rd_next;
    t_link r_head_q;

    // result and response
    t_val  r_res_value;
    t_stat r_res_status;
    t_val  r_out_value;
    t_stat r_out_status;
    t_link r_out_count;
    logic  r_out_valid;

    logic  accept;
    logic  prev_nil;
    t_val  new_val;
    t_idx  rd_addr;
    logic  rd_en;
    logic  val_we;
    t_idx  val_wa;
    t_val  val_wd;
    logic  next_we;
    t_idx  next_wa;
    t_link next_wd;
    logic  head_we;
    t_link head_wd;

    assign accept   = i_req.valid && i_cmd.in_ready;
    assign prev_nil = (r_prev >= NIL_LINK);
    assign new_val  = (r_mode == MODE_INSERT) ? r_val : r_default;

    assign i_req.ready = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_value;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.entry_count  = COUNT_BITS'(r_out_count);

    assign o_sts.req_valid  = i_req.valid;
    assign o_sts.out_free   = !r_out_valid || o_rsp.ready;
    assign o_sts.cur_nil    = (r_cur >= NIL_LINK);
    assign o_sts.step_limit = (r_steps >= POOL_LAST);
    assign o_sts.key_match  = (r_rd_key == r_key);
    assign o_sts.free_nil   = (r_free_head >= NIL_LINK);
    assign o_sts.pool_full  = (r_fill >= POOL_LAST);
    assign o_sts.mode       = r_mode;

    // memory port selection
    assign rd_en   = i_cmd.ent_rd || i_cmd.ent_rd_free;
    assign rd_addr = i_cmd.ent_rd_free ? r_free_head[IDX_W-1:0] : r_cur[IDX_W-1:0];

    assign val_we = i_cmd.wr_val_upd || i_cmd.create;
    assign val_wa = i_cmd.create ? r_slot[IDX_W-1:0] : r_cur[IDX_W-1:0];
    assign val_wd = i_cmd.create ? new_val : r_val;

    assign next_we = (i_cmd.unlink && !prev_nil) || i_cmd.free_push || i_cmd.create;
    assign next_wa = i_cmd.create    ? r_slot[IDX_W-1:0] :
                     i_cmd.free_push ? r_cur[IDX_W-1:0]  : r_prev[IDX_W-1:0];
    assign next_wd = i_cmd.create    ? r_head      :
                     i_cmd.free_push ? r_free_head : r_rd_next;

    assign head_we = (i_cmd.unlink && prev_nil) || i_cmd.create;
    assign head_wd = i_cmd.create ? r_slot : r_rd_next;

    // entry memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.create) begin
            m_key[r_slot[IDX_W-1:0]] <= r_key;
        end
        if (val_we) begin
            m_val[val_wa] <= val_wd;
        end
        if (next_we) begin
            m_next[next_wa] <= next_wd;
        end
        if (rd_en) begin
            r_rd_key  <= m_key[rd_addr];
            r_rd_val  <= m_val[rd_addr];
            r_rd_next <= m_next[rd_addr];
        end
    end

    // bucket head memory
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            m_head[r_bkt] <= head_wd;
        end
        if (i_cmd.head_rd) begin
            r_head_q <= r_hvalid[r_bkt] ? m_head[r_bkt] : NIL_LINK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= '0;
        end else if (head_we) begin
            r_hvalid[r_bkt] <= 1'b1;
        end
    end

    // request capture and chain walk
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_req.mode;
            r_key  <= i_req.key;
            r_val  <= i_req.value;
            r_bkt  <= bucket_of(i_req.key);
        end
        if (i_cmd.head_load) begin
            r_cur   <= r_head_q;
            r_head  <= r_head_q;
            r_prev  <= NIL_LINK;
            r_steps <= '0;
        end else if (i_cmd.advance) begin
            r_prev  <= r_cur;
            r_cur   <= r_rd_next;
            r_steps <= r_steps + t_link'(1);
        end
        if (i_cmd.pop_free) begin
            r_slot <= r_free_head;
        end else if (i_cmd.bump) begin
            r_slot <= r_fill;
        end
        if (i_cmd.res_ld) begin
            r_res_status <= i_cmd.res_status;
            case (i_cmd.res_status)
                ST_HIT:  r_res_value <= (r_mode == MODE_INSERT) ? r_val : r_rd_val;
                ST_NEW:  r_res_value <= new_val;
                default: r_res_value <= '0;
            endcase
        end
    end

    // free list, fill pointer, live count and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= NIL_LINK;
            r_fill      <= '0;
            r_live      <= '0;
            r_default   <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_default <= i_cfg.data;
            end
            if (i_cmd.free_push) begin
                r_free_head <= r_cur;
            end else if (i_cmd.pop_free) begin
                r_free_head <= r_rd_next;
            end
            if (i_cmd.bump) begin
                r_fill <= r_fill + t_link'(1);
            end
            if (i_cmd.free_push && r_live != '0) begin
                r_live <= r_live - t_link'(1);
            end else if (i_cmd.create) begin
                r_live <= r_live + t_link'(1);
            end
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
            r_out_count  <= r_live;
        end
    end

endmodule

>>> hdl/chained_hash_map_engine_top.sv
// top level of the chained hash map engine: sequencer plus datapath
// depends on chm_pkg, chm_if, chm_ctrl and chm_dp
//
//   channel  dir  payload                                   word accepted when
//   i_req    in   mode, key, value                          valid && ready
//   o_rsp    out  result_value, status, entry_count         valid && ready
//   i_cfg    in   data (default value for lookup-or-create) valid && ready
//
// a request passes the bucket head read and head load, then per chain entry an entry memory
// read and key compare, then the hit or miss state before the response register; remove adds
// a free-list push, creating an entry adds a create step, with a free-list pop first when reusing a freed slot
// one request is in flight at a time; the next is taken while a response waits
// bucket heads carry reset-cleared valid bits, so no clearing pass is needed
// a stalled response holds the sequencer in its final state until taken
module chained_hash_map_engine_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    chm_req_if.sink   i_req,
    chm_rsp_if.source o_rsp,
    chm_cfg_if.sink   i_cfg
);
    import chm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    chm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    chm_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (i_cfg),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

>>> tb/testbench.sv
// self-checking testbench for chained_hash_map_engine_top: directed then random requests
// a scoreboard class predicts each response word from its own copy of the chained table
// depends on chm_pkg, chm_if and the engine rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import chm_pkg::*;

    localparam int   KEY_LOG = 256;
    localparam t_key KEY_A   = 32'h0000_0000;
    localparam t_key KEY_B   = 32'h0000_0200;
    localparam t_key KEY_C   = 32'hFFFF_FE03;
    localparam t_key KEY_D   = 32'hFFFF_FFFF;

    typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} t_mix;

    class hash_map_scoreboard;
        typedef struct packed {
            t_val                  value;
            t_stat                 status;
            logic [COUNT_BITS-1:0] count;
        } t_outcome;

        t_link                 head_link [BUCKETS];
        t_key                  slot_key  [POOL_SIZE];
        t_val                  slot_val  [POOL_SIZE];
        t_link                 slot_next [POOL_SIZE];
        t_link                 free_link;
        t_link                 fill_mark;
        logic [COUNT_BITS-1:0] live;
        t_val                  create_value;
        t_outcome              awaited [$];
        int                    errors;

        function new();
            foreach (head_link[i]) head_link[i] = NIL_LINK;
            foreach (slot_key[i]) begin
                slot_key[i]  = '0;
                slot_val[i]  = '0;
                slot_next[i] = '0;
            end
            free_link    = NIL_LINK;
            fill_mark    = '0;
            live         = '0;
            create_value = '0;
            errors       = 0;
        endfunction

        function void note_request(t_mode m, t_key k, t_val v);
            t_bkt     b;
            t_link    cur;
            t_link    prev;
            t_link    hit;
            t_link    hit_prev;
            t_link    s;
            int       steps;
            t_outcome o;
            b        = k[BKT_W+1:2];
            cur      = head_link[b];
            prev     = NIL_LINK;
            hit      = NIL_LINK;
            hit_prev = NIL_LINK;
            steps    = 0;
            while (cur < NIL_LINK && steps < POOL_SIZE && hit == NIL_LINK) begin
                if (slot_key[cur] == k) begin
                    hit      = cur;
                    hit_prev = prev;
                end else begin
                    prev = cur;
                    cur  = slot_next[cur];
                end
                steps++;
            end
            o.value = '0;
            if (hit != NIL_LINK) begin
                o.status = ST_HIT;
                if (m == MODE_INSERT) slot_val[hit] = v;
                o.value = slot_val[hit];
                if (m == MODE_REMOVE) begin
                    if (hit_prev != NIL_LINK) slot_next[hit_prev] = slot_next[hit];
                    else head_link[b] = slot_next[hit];
                    slot_next[hit] = free_link;
                    free_link      = hit;
                    if (live > 0) live--;
                end
            end else if (m == MODE_LOOKUP || m == MODE_REMOVE) begin
                o.status = ST_ABSENT;
            end else begin
                if (free_link != NIL_LINK) begin
                    s         = free_link;
                    free_link = slot_next[s];
                end else if (fill_mark < POOL_SIZE) begin
                    s = fill_mark;
                    fill_mark++;
                end else begin
                    s = NIL_LINK;
                end
                if (s == NIL_LINK) begin
                    o.status = ST_FULL;
                end else begin
                    slot_key[s]  = k;
                    slot_val[s]  = (m == MODE_INSERT) ? v : create_value;
                    slot_next[s] = head_link[b];
                    head_link[b] = s;
                    live++;
                    o.status = ST_NEW;
                    o.value  = slot_val[s];
                end
            end
            o.count = live;
            awaited.push_back(o);
        endfunction

        function void check_response(t_val v, t_stat st, logic [COUNT_BITS-1:0] c);
            t_outcome o;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected word: value %h status %0d count %0d",
                         $time, v, st, c);
                errors++;
                return;
            end
            o = awaited.pop_front();
            if (v !== o.value) begin
                $display("%0t: result_value expected %h actual %h", $time, o.value, v);
                errors++;
            end
            if (st !== o.status) begin
                $display("%0t: status expected %0d actual %0d", $time, o.status, st);
                errors++;
            end
            if (c !== o.count) begin
                $display("%0t: entry_count expected %0d actual %0d", $time, o.count, c);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   idle_pct;
    int   stall_pct;
    t_key key_log [KEY_LOG];

    hash_map_scoreboard sb;

    chm_req_if req ();
    chm_rsp_if rsp ();
    chm_cfg_if cfg ();

    chained_hash_map_engine_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .i_cfg   (cfg)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        rsp.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready)
            sb.check_response(rsp.result_value, rsp.status, rsp.entry_count);
    end

    function automatic t_key pick_key(int fresh_pct);
        t_key k;
        int   r;
        r = $urandom_range(99);
        if (r < 2) begin
            k = '0;
        end else if (r < 4) begin
            k = '1;
        end else if (r < 4 + fresh_pct) begin
            k = $urandom;
            // crowd some keys into a few buckets for longer chains
            if ($urandom_range(3) == 0) k[BKT_W+1:2] = t_bkt'($urandom_range(7));
        end else begin
            k = key_log[$urandom_range(KEY_LOG-1)];
        end
        return k;
    endfunction

    function automatic t_mode pick_mode(t_mix mix);
        int r;
        r = $urandom_range(99);
        case (mix)
            MIX_FILL: begin
                if (r < 45) return MODE_INSERT;
                if (r < 90) return MODE_CREATE;
                return MODE_LOOKUP;
            end
            MIX_DRAIN: begin
                if (r < 60) return MODE_REMOVE;
                if (r < 80) return MODE_LOOKUP;
                return MODE_INSERT;
            end
            default: begin
                if (r < 25) return MODE_LOOKUP;
                if (r < 50) return MODE_INSERT;
                if (r < 75) return MODE_REMOVE;
                return MODE_CREATE;
            end
        endcase
    endfunction

    function automatic t_val pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return $urandom;
    endfunction

    // called at a falling edge; leaves valid high so back-to-back words need no gap
    task automatic send_request(t_mode m, t_key k, t_val v);
        while ($urandom_range(99) < idle_pct) begin
            req.valid <= 1'b0;
            @(negedge i_clk);
        end
        req.valid <= 1'b1;
        req.mode  <= m;
        req.key   <= k;
        req.value <= v;
        do @(posedge i_clk); while (!req.ready);
        sb.note_request(m, k, v);
        if (m == MODE_INSERT || m == MODE_CREATE) key_log[$urandom_range(KEY_LOG-1)] = k;
        @(negedge i_clk);
    endtask

    task automatic drain_responses();
        req.valid <= 1'b0;
        do @(negedge i_clk); while (sb.awaited.size() != 0);
    endtask

    task automatic write_default(t_val d);
        drain_responses();
        cfg.valid <= 1'b1;
        cfg.data  <= d;
        do @(posedge i_clk); while (!cfg.ready);
        sb.create_value = d;
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic run_phase(t_mix mix, int n, int idle, int stall, t_val d);
        int    fresh;
        t_mode m;
        t_key  k;
        write_default(d);
        idle_pct  = idle;
        stall_pct = stall;
        fresh     = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 5 : 20;
        repeat (n) begin
            m = pick_mode(mix);
            k = pick_key(fresh);
            send_request(m, k, pick_value());
        end
    endtask

    initial begin
        sb        = new();
        idle_pct  = 0;
        stall_pct = 0;
        foreach (key_log[i]) begin
            key_log[i] = $urandom;
            if (i % 4 == 0) key_log[i][BKT_W+1:2] = t_bkt'($urandom_range(7));
        end
        req.valid = 1'b0;
        req.mode  = MODE_LOOKUP;
        req.key   = '0;
        req.value = '0;
        cfg.valid = 1'b0;
        cfg.data  = '0;
        rsp.ready = 1'b0;
        i_rst_n   = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // keys a, b and c share bucket zero, key d sits in the last bucket
        send_request(MODE_LOOKUP, KEY_A, 32'h1234_5678);
        send_request(MODE_REMOVE, KEY_A, '0);
        send_request(MODE_CREATE, KEY_A, '1);
        send_request(MODE_INSERT, KEY_B, '1);
        send_request(MODE_INSERT, KEY_C, '0);
        send_request(MODE_LOOKUP, KEY_A, '0);
        send_request(MODE_INSERT, KEY_A, 32'h5A5A_5A5A);
        send_request(MODE_CREATE, KEY_B, '0);
        send_request(MODE_REMOVE, KEY_B, '0);
        send_request(MODE_REMOVE, KEY_C, '0);
        send_request(MODE_LOOKUP, KEY_B, '0);
        write_default('1);
        send_request(MODE_CREATE, KEY_D, '0);
        send_request(MODE_INSERT, KEY_B, 32'hA5A5_A5A5);
        send_request(MODE_INSERT, KEY_D, '1);
        send_request(MODE_REMOVE, KEY_A, '0);
        send_request(MODE_REMOVE, KEY_A, '0);
        send_request(MODE_LOOKUP, KEY_D, '0);
        send_request(MODE_REMOVE, KEY_D, '0);
        send_request(MODE_CREATE, 32'h0000_0004, '0);
        send_request(MODE_LOOKUP, 32'h8000_0000, '0);

        run_phase(MIX_BALANCED, 200, 0, 0, $urandom);
        run_phase(MIX_FILL, 330, 49, 0, '1);
        run_phase(MIX_DRAIN, 250, 0, 49, '0);
        run_phase(MIX_BALANCED, 250, 26, 26, $urandom);
        run_phase(MIX_FILL, 330, 0, 0, 32'h8000_0001);
        run_phase(MIX_DRAIN, 200, 49, 0, $urandom);
        run_phase(MIX_BALANCED, 200, 0, 49, '0);
        run_phase(MIX_BALANCED, 170, 26, 26, '1);

        drain_responses();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule

>>> files.f
hdl/chm_pkg.sv
hdl/chm_if.sv
hdl/chm_ctrl.sv
hdl/chm_dp.sv
hdl/chained_hash_map_engine_top.sv
tb/testbench.sv
